>>> src/sc2c_pkg.sv
// ----------------------------------------------------------------------------
// sc2c_pkg - shared definitions for the QWERTZ scan-code translator
// Holds the word widths, the special key codes and the layout tables.
// ----------------------------------------------------------------------------
`default_nettype none

package sc2c_pkg;

   localparam int ScanWidth = 8;
   localparam int CharWidth = 8;
   localparam int CodeWidth = 7;

   typedef logic [ScanWidth-1:0] scan_type;
   typedef logic [CharWidth-1:0] char_type;
   typedef logic [CodeWidth-1:0] code_type;

   // Special key codes (release bit stripped).
   localparam code_type CodeEscape    = 7'd1;
   localparam code_type CodeCtrl      = 7'd29;
   localparam code_type CodeShift     = 7'h2A;
   localparam code_type CodeAlt       = 7'd56;
   localparam code_type CodeCaps      = 7'h3A;
   localparam code_type CodeFkeyFirst = 7'd59;
   localparam code_type CodeFkeyLast  = 7'd68;
   localparam code_type CodeF11       = 7'd87;
   localparam code_type CodeF12       = 7'd88;
   localparam code_type CodeAltgr     = 7'h60;

   localparam int MainLen  = 59;
   localparam int AltgrLen = 10;

   // Result of the translation of one scan word.
   typedef struct packed {
      logic     emit;
      char_type char_code;
   } sc2c_result_type;

   localparam char_type LowerTab [MainLen] = '{
      8'd0, 8'd0, "1", "2", "3", "4", "5", "6", "7", "8", "9", "0", 8'd223, 8'd180, 8'd8,
      8'd9, "q", "w", "e", "r", "t", "z", "u", "i", "o", "p", 8'd252, "+", 8'd13, 8'd0,
      "a", "s", "d", "f", "g", "h", "j", "k", "l", 8'd246, 8'd228, "^", 8'd0, "<",
      "y", "x", "c", "v", "b", "n", "m", ",", ".", "-", 8'd0, 8'd0, 8'd0, " ", 8'd0
   };

   localparam char_type UpperTab [MainLen] = '{
      8'd0, 8'd0, "!", 8'h22, "3", "$", "%", "&", "/", "(", ")", "=", "?", 8'h60, 8'd8,
      8'd9, "Q", "W", "E", "R", "T", "Z", "U", "I", "O", "P", 8'd220, "*", 8'd13, 8'd0,
      "A", "S", "D", "F", "G", "H", "J", "K", "L", 8'd214, 8'd196, "^", 8'd0, ">",
      "Y", "X", "C", "V", "B", "N", "M", ";", ":", "_", 8'd0, 8'd0, 8'd0, " ", 8'd0
   };

   localparam char_type AltgrTab [AltgrLen] = '{
      8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, "{", "["
   };

   // Table reads past the end of a table return zero.
   function automatic char_type lower_lookup(code_type code);
      char_type ch;
      ch = 8'd0;
      if (code < code_type'(MainLen)) begin
         ch = LowerTab[code[5:0]];
      end
      return ch;
   endfunction

   function automatic char_type upper_lookup(code_type code);
      char_type ch;
      ch = 8'd0;
      if (code < code_type'(MainLen)) begin
         ch = UpperTab[code[5:0]];
      end
      return ch;
   endfunction

   function automatic char_type altgr_lookup(code_type code);
      char_type ch;
      ch = 8'd0;
      if (code < code_type'(AltgrLen)) begin
         ch = AltgrTab[code[3:0]];
      end
      return ch;
   endfunction

endpackage

`default_nettype wire

>>> src/sc2c_ifs.sv
// ----------------------------------------------------------------------------
// sc2c_ifs - stream interfaces of the scan-code translator
// Valid/ready channels for scan words in and character words out.
// ----------------------------------------------------------------------------
`default_nettype none

interface sc2c_req_if;
   logic                           valid;
   logic                           ready;
   logic [sc2c_pkg::ScanWidth-1:0] scan_byte;

   modport source (output valid, output scan_byte, input ready);
   modport sink   (input valid, input scan_byte, output ready);
endinterface

interface sc2c_rsp_if;
   logic                           valid;
   logic                           ready;
   logic [sc2c_pkg::CharWidth-1:0] char_code;

   modport source (output valid, output char_code, input ready);
   modport sink   (input valid, input char_code, output ready);
endinterface

`default_nettype wire

>>> src/sc2c_in_stage.sv
// ----------------------------------------------------------------------------
// sc2c_in_stage - input register
// Captures one scan word and holds it until the translate step consumes it.
// ----------------------------------------------------------------------------
`default_nettype none

module sc2c_in_stage (
   input  logic                clock,
   input  logic                reset,
   input  logic                in_valid,
   input  sc2c_pkg::scan_type  in_scan,
   output logic                in_ready,
   input  logic                advance,
   output logic                hold_valid,
   output sc2c_pkg::scan_type  hold_scan
);
   import sc2c_pkg::*;

   logic     valid_ff, valid_in;
   scan_type scan_ff, scan_in;

   assign in_ready = !valid_ff || advance;

   always_comb begin
      valid_in = valid_ff;
      scan_in  = scan_ff;
      if (in_valid && in_ready) begin
         valid_in = 1'b1;
         scan_in  = in_scan;
      end else if (advance) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      scan_ff <= scan_in;
   end

   assign hold_valid = valid_ff;
   assign hold_scan  = scan_ff;

endmodule

`default_nettype wire

>>> src/sc2c_xlate.sv
// ----------------------------------------------------------------------------
// sc2c_xlate - modifier flags and layout lookup
// Decodes one scan word, updates shift, caps lock and AltGr, picks a character.
// ----------------------------------------------------------------------------
`default_nettype none

module sc2c_xlate (
   input  logic                     clock,
   input  logic                     reset,
   input  sc2c_pkg::scan_type       scan,
   input  logic                     advance,
   output sc2c_pkg::sc2c_result_type result
);
   import sc2c_pkg::*;

   code_type code;
   logic     released;
   logic     ignored;
   logic     is_shift, is_caps, is_altgr;
   logic     shift_ff, shift_in;
   logic     caps_ff, caps_in;
   logic     altgr_ff, altgr_in;

   assign code     = scan[CodeWidth-1:0];
   assign released = scan[ScanWidth-1];
   assign ignored  = (code == CodeEscape) || (code == CodeCtrl) || (code == CodeAlt)
                   || (code == CodeF11) || (code == CodeF12)
                   || ((code >= CodeFkeyFirst) && (code <= CodeFkeyLast));
   assign is_shift = (code == CodeShift);
   assign is_caps  = (code == CodeCaps);
   assign is_altgr = (code == CodeAltgr);

   // Shift and AltGr flip on both edges of the key, so they track a held key.
   assign shift_in = shift_ff ^ (advance && is_shift);
   assign altgr_in = altgr_ff ^ (advance && is_altgr);
   assign caps_in  = caps_ff ^ (advance && is_caps && !released);

   always_ff @(posedge clock) begin
      if (reset) begin
         shift_ff <= 1'b0;
         caps_ff  <= 1'b0;
         altgr_ff <= 1'b0;
      end else begin
         shift_ff <= shift_in;
         caps_ff  <= caps_in;
         altgr_ff <= altgr_in;
      end
   end

   always_comb begin
      result.emit = !ignored && !is_shift && !is_caps && !is_altgr && !released;
      priority if (shift_ff || caps_ff) begin
         result.char_code = upper_lookup(code);
      end else if (altgr_ff) begin
         result.char_code = altgr_lookup(code);
      end else begin
         result.char_code = lower_lookup(code);
      end
   end

   // Modifier and ignored keys never produce a character.
   a_no_emit_special: assert property (@(posedge clock) disable iff (reset)
      (ignored || is_shift || is_caps || is_altgr) |-> !result.emit)
      else $error("special key produced a character");

   // A caps lock release leaves the caps flag untouched.
   a_caps_release: assert property (@(posedge clock) disable iff (reset)
      (advance && is_caps && released) |=> (caps_ff == $past(caps_ff)))
      else $error("caps lock changed on release");

   // Flags only move when a word is consumed.
   a_flags_hold: assert property (@(posedge clock) disable iff (reset)
      !advance |=> ($stable(shift_ff) && $stable(caps_ff) && $stable(altgr_ff)))
      else $error("modifier flag changed without a consumed word");

endmodule

`default_nettype wire

>>> src/sc2c_out_stage.sv
// ----------------------------------------------------------------------------
// sc2c_out_stage - result register
// Holds one character word until the receiver takes it.
// ----------------------------------------------------------------------------
`default_nettype none

module sc2c_out_stage (
   input  logic                clock,
   input  logic                reset,
   input  logic                load,
   input  sc2c_pkg::char_type  load_char,
   output logic                free,
   output logic                out_valid,
   output sc2c_pkg::char_type  out_char,
   input  logic                out_ready
);
   import sc2c_pkg::*;

   logic     valid_ff, valid_in;
   char_type char_ff, char_in;

   // The slot is free when empty or when its word leaves this cycle.
   assign free = !valid_ff || out_ready;

   always_comb begin
      valid_in = valid_ff;
      char_in  = char_ff;
      if (load) begin
         valid_in = 1'b1;
         char_in  = load_char;
      end else if (out_ready) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      char_ff <= char_in;
   end

   assign out_valid = valid_ff;
   assign out_char  = char_ff;

endmodule

`default_nettype wire

>>> src/scancode_to_char_qwertz_core.sv
// ----------------------------------------------------------------------------
// scancode_to_char_qwertz_core - set-1 scan byte to Latin-1 translator (QWERTZ)
//
// The request channel carries raw set-1 scan words: bit 7 set marks a key
// release, bits 6..0 are the key code. Each pressed ordinary key produces one
// Latin-1 character word on the response channel, taken from the German
// layout (upper case with shift or caps lock, AltGr table with AltGr, lower
// case otherwise). Releases, the modifier keys and the ignored keys (escape,
// control, alt, function keys) produce no word. Shift and AltGr flip on press
// and release, caps lock flips on press.
// A scan word is registered on acceptance in the input register, translated
// there, and its character is written into the result register when the
// word moves on; the response valid comes from that result register. Unless
// a character must wait for the result register, one scan word is accepted
// every cycle; the combinational table lookup and flag update set that rate.
// Reset clears all three modifier flags and empties both registers.
// When the receiver stalls the result register holds its word; words that
// produce nothing still drain, and the request channel only backs up once a
// character must wait behind the held one.
// ----------------------------------------------------------------------------
`default_nettype none

module scancode_to_char_qwertz_core (
   input  logic              clock,
   input  logic              reset,
   sc2c_req_if.sink          req_ch,
   sc2c_rsp_if.source        rsp_ch
);
   import sc2c_pkg::*;

   logic            hold_valid;
   scan_type        hold_scan;
   logic            advance;
   logic            out_free;
   sc2c_result_type result;

   // Input register.
   sc2c_in_stage u_in_stage (
      .clock      (clock),
      .reset      (reset),
      .in_valid   (req_ch.valid),
      .in_scan    (req_ch.scan_byte),
      .in_ready   (req_ch.ready),
      .advance    (advance),
      .hold_valid (hold_valid),
      .hold_scan  (hold_scan)
   );

   // Flag state and table lookup.
   sc2c_xlate u_xlate (
      .clock   (clock),
      .reset   (reset),
      .scan    (hold_scan),
      .advance (advance),
      .result  (result)
   );

   // A held word moves on when it yields nothing or the result slot is free.
   assign advance = hold_valid && (!result.emit || out_free);

   // Result register.
   sc2c_out_stage u_out_stage (
      .clock     (clock),
      .reset     (reset),
      .load      (advance && result.emit),
      .load_char (result.char_code),
      .free      (out_free),
      .out_valid (rsp_ch.valid),
      .out_char  (rsp_ch.char_code),
      .out_ready (rsp_ch.ready)
   );

   // An empty input register always takes a word.
   a_empty_ready: assert property (@(posedge clock) disable iff (reset)
      !hold_valid |-> req_ch.ready)
      else $error("input register empty but not ready");

   // A new character appears only after a held word was consumed.
   a_rsp_source: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_ch.valid) |-> $past(advance && result.emit))
      else $error("character word without a translated scan word");

   // A character is never loaded over a word the receiver has not taken.
   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      (advance && result.emit) |-> (!rsp_ch.valid || rsp_ch.ready))
      else $error("result register overwritten");

endmodule

`default_nettype wire

>>> dv/sc2c_scoreboard.sv
// ----------------------------------------------------------------------------
// sc2c_scoreboard - character predictor and checker for the QWERTZ translator
// Watches both channels, keeps its own copy of the modifier flags, predicts
// the character word of every accepted scan word and compares each accepted
// character word with the oldest prediction.
// ----------------------------------------------------------------------------
`default_nettype none

module sc2c_scoreboard (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   input  logic               req_ready,
   input  sc2c_pkg::scan_type req_scan_byte,
   input  logic               rsp_valid,
   input  logic               rsp_ready,
   input  sc2c_pkg::char_type rsp_char_code,
   input  logic               end_of_test,
   output int                 fail_count,
   output int                 pending_count
);
   import sc2c_pkg::*;

   // Independent copy of the German layout.
   char_type lower_chars [59] = '{
      8'h00, 8'h00, "1", "2", "3", "4", "5", "6", "7", "8", "9", "0",
      8'hDF, 8'hB4, 8'h08, 8'h09, "q", "w", "e", "r", "t", "z", "u", "i",
      "o", "p", 8'hFC, "+", 8'h0D, 8'h00, "a", "s", "d", "f", "g", "h",
      "j", "k", "l", 8'hF6, 8'hE4, "^", 8'h00, "<", "y", "x", "c", "v",
      "b", "n", "m", ",", ".", "-", 8'h00, 8'h00, 8'h00, " ", 8'h00
   };

   char_type upper_chars [59] = '{
      8'h00, 8'h00, "!", 8'h22, "3", "$", "%", "&", "/", "(", ")", "=",
      "?", 8'h60, 8'h08, 8'h09, "Q", "W", "E", "R", "T", "Z", "U", "I",
      "O", "P", 8'hDC, "*", 8'h0D, 8'h00, "A", "S", "D", "F", "G", "H",
      "J", "K", "L", 8'hD6, 8'hC4, "^", 8'h00, ">", "Y", "X", "C", "V",
      "B", "N", "M", ";", ":", "_", 8'h00, 8'h00, 8'h00, " ", 8'h00
   };

   char_type altgr_chars [10] = '{
      8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, "{", "["
   };

   logic     shift_held;
   logic     caps_locked;
   logic     altgr_held;
   char_type expected_chars [$];

   initial begin
      fail_count    = 0;
      pending_count = 0;
      shift_held    = 1'b0;
      caps_locked   = 1'b0;
      altgr_held    = 1'b0;
   end

   task automatic report_mismatch(input string what);
      $display("[%0t] mismatch: %s", $realtime, what);
      fail_count++;
   endtask

   // Updates the flags for one scan word and queues the character it yields.
   task automatic predict_char(input scan_type word);
      code_type key;
      logic     released;
      char_type ch;
      key      = word[6:0];
      released = word[7];
      ch       = 8'h00;
      if (key == CodeEscape || key == CodeCtrl || key == CodeAlt || key == CodeF11 ||
          key == CodeF12 || (key >= CodeFkeyFirst && key <= CodeFkeyLast)) begin
         // Ignored keys leave everything as it is.
      end else if (key == CodeAltgr) begin
         altgr_held = !altgr_held;
      end else if (key == CodeShift) begin
         shift_held = !shift_held;
      end else if (key == CodeCaps) begin
         if (!released) begin
            caps_locked = !caps_locked;
         end
      end else if (!released) begin
         if (shift_held || caps_locked) begin
            if (key < 7'd59) begin
               ch = upper_chars[key[5:0]];
            end
         end else if (altgr_held) begin
            if (key < 7'd10) begin
               ch = altgr_chars[key[3:0]];
            end
         end else if (key < 7'd59) begin
            ch = lower_chars[key[5:0]];
         end
         expected_chars.push_back(ch);
      end
   endtask

   always @(posedge clock) begin
      char_type want;
      if (reset) begin
         shift_held  = 1'b0;
         caps_locked = 1'b0;
         altgr_held  = 1'b0;
         expected_chars.delete();
      end else begin
         // A character word always stems from an earlier scan word, so the
         // output side is handled first.
         if (rsp_valid === 1'b1 && rsp_ready === 1'b1) begin
            if (expected_chars.size() == 0) begin
               report_mismatch($sformatf("char word 0x%02h with nothing expected",
                                         rsp_char_code));
            end else begin
               want = expected_chars.pop_front();
               if (rsp_char_code !== want) begin
                  report_mismatch($sformatf("char_code 0x%02h, expected 0x%02h",
                                            rsp_char_code, want));
               end
            end
         end
         if (req_valid === 1'b1 && req_ready === 1'b1) begin
            predict_char(req_scan_byte);
         end
         if (end_of_test && expected_chars.size() != 0) begin
            report_mismatch($sformatf("%0d char words never arrived",
                                      expected_chars.size()));
            expected_chars.delete();
         end
      end
      pending_count = expected_chars.size();
   end

endmodule

`default_nettype wire

>>> dv/testbench.sv
// ----------------------------------------------------------------------------
// testbench - top level of the QWERTZ translator verification
// Drives scan words into the core, pulls character words out with random
// back-pressure, and lets the scoreboard judge every character word.
// ----------------------------------------------------------------------------
`default_nettype none

module testbench;
   import sc2c_pkg::*;

   // Total number of scan words in the run, and where the calm tail begins.
   localparam int WordTotal  = 1150;
   localparam int CalmStart  = 1000;
   localparam int StallStart = 500;

   logic clock;
   logic reset;
   logic end_of_test;
   logic idle_enable;
   logic long_stall_req;
   int   fail_count;
   int   pending_count;
   int   words_sent;

   sc2c_req_if req_if ();
   sc2c_rsp_if rsp_if ();

   scancode_to_char_qwertz_core DUT (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_if),
      .rsp_ch (rsp_if)
   );

   // The scoreboard sees exactly what crosses each channel.
   sc2c_scoreboard u_scoreboard (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_if.valid),
      .req_ready     (req_if.ready),
      .req_scan_byte (req_if.scan_byte),
      .rsp_valid     (rsp_if.valid),
      .rsp_ready     (rsp_if.ready),
      .rsp_char_code (rsp_if.char_code),
      .end_of_test   (end_of_test),
      .fail_count    (fail_count),
      .pending_count (pending_count)
   );

   // Free-running clock with a period of 20 time units.
   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   // Watchdog. The slowest legal run stays far below this time.
   initial begin
      #4000000;
      $display("Regression FAIL");
      $finish;
   end

   // A key that yields a character from the main tables: not a modifier and
   // not one of the keys that the core skips.
   function automatic logic is_plain_key(input code_type key);
      return !(key == CodeEscape || key == CodeCtrl || key == CodeAlt ||
               key == CodeShift || key == CodeCaps || key == CodeF11 ||
               key == CodeF12 || key == CodeAltgr ||
               (key >= CodeFkeyFirst && key <= CodeFkeyLast));
   endfunction

   function automatic code_type pick_key();
      code_type key;
      do begin
         key = code_type'($urandom_range(0, 58));
      end while (!is_plain_key(key));
      return key;
   endfunction

   // Offers one scan word and returns at the falling edge after it was taken.
   // Every call starts at a falling edge, where only valid and the scan word
   // change; an optional idle burst comes first.
   task automatic push_scan(input scan_type word);
      if (idle_enable && $urandom_range(0, 5) == 0) begin
         req_if.valid <= 1'b0;
         repeat ($urandom_range(1, 4)) @(negedge clock);
      end
      req_if.valid     <= 1'b1;
      req_if.scan_byte <= word;
      forever begin
         @(posedge clock);
         if (req_if.ready === 1'b1) break;
      end
      words_sent++;
      @(negedge clock);
   endtask

   // A key press, usually followed by its release.
   task automatic type_key(input code_type key);
      push_scan({1'b0, key});
      if ($urandom_range(0, 3) != 0) begin
         push_scan({1'b1, key});
      end
   endtask

   // Receiver. It stalls in short random bursts, and once for a long stretch
   // on request so that the core fills up and backs up the scan channel.
   initial begin
      rsp_if.ready = 1'b0;
      forever begin
         @(negedge clock);
         if (long_stall_req) begin
            rsp_if.ready <= 1'b0;
            repeat (80) @(negedge clock);
            long_stall_req = 1'b0;
         end else if (idle_enable && $urandom_range(0, 4) == 0) begin
            rsp_if.ready <= 1'b0;
            repeat ($urandom_range(1, 4) - 1) @(negedge clock);
         end else begin
            rsp_if.ready <= 1'b1;
         end
      end
   end

   // Stimulus and verdict.
   initial begin
      scan_type directed_words [27];
      int       choice;
      logic     pressure_done;

      req_if.valid     = 1'b0;
      req_if.scan_byte = '0;
      reset            = 1'b1;
      end_of_test      = 1'b0;
      idle_enable      = 1'b1;
      long_stall_req   = 1'b0;
      words_sent       = 0;
      pressure_done    = 1'b0;

      // Directed opening. First the keys that the core skips, one of them
      // released. Then a plain key with its release, code zero, the top code
      // that lies past every table, its release, and the right shift key,
      // which maps to zero. Caps lock is tried on press and release, shift
      // as a held modifier, and AltGr with its two mapped keys and one key
      // just past the end of its table.
      directed_words = '{
         {1'b0, CodeEscape}, {1'b0, CodeCtrl}, {1'b0, CodeAlt},
         {1'b0, CodeFkeyFirst}, {1'b0, CodeFkeyLast}, {1'b0, CodeF11},
         {1'b1, CodeF12},
         8'h10, 8'h90, 8'h00, 8'h7F, 8'hFF, 8'h36,
         {1'b0, CodeCaps}, 8'h1E, {1'b1, CodeCaps}, 8'h1E, {1'b0, CodeCaps},
         {1'b0, CodeShift}, 8'h0C, 8'h29, {1'b1, CodeShift},
         {1'b0, CodeAltgr}, 8'h08, 8'h09, 8'h0A, {1'b1, CodeAltgr}
      };

      // Reset is held first, then released at a falling edge.
      repeat (12) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      foreach (directed_words[i]) begin
         push_scan(directed_words[i]);
      end

      // Random part. Most of it is well-formed typing: plain keys, keys
      // wrapped in shift or AltGr, caps lock toggles. The rest is keys past
      // the tables and raw noise, which also knocks the flags out of step.
      while (words_sent < WordTotal) begin
         if (words_sent >= CalmStart) begin
            idle_enable = 1'b0;
         end
         if (!pressure_done && words_sent >= StallStart) begin
            // The receiver stops while the sender keeps typing characters.
            pressure_done  = 1'b1;
            long_stall_req = 1'b1;
            repeat (40) type_key(pick_key());
         end
         choice = $urandom_range(0, 9);
         case (choice)
            0, 1: begin
               push_scan({1'b0, CodeShift});
               repeat ($urandom_range(1, 3)) type_key(pick_key());
               push_scan({1'b1, CodeShift});
            end
            2: begin
               push_scan({1'b0, CodeAltgr});
               type_key(code_type'($urandom_range(0, 12)));
               push_scan({1'b1, CodeAltgr});
            end
            3: begin
               push_scan({1'b0, CodeCaps});
               if ($urandom_range(0, 1) == 1) begin
                  push_scan({1'b1, CodeCaps});
               end
            end
            4, 5, 6: begin
               type_key(pick_key());
            end
            7: begin
               type_key(code_type'($urandom_range(59, 127)));
            end
            default: begin
               push_scan(scan_type'($urandom_range(0, 255)));
            end
         endcase
      end

      // Drain: wait for every predicted character, then for anything stray,
      // then let the scoreboard flag leftovers.
      req_if.valid <= 1'b0;
      while (pending_count != 0) @(negedge clock);
      repeat (10) @(negedge clock);
      end_of_test <= 1'b1;
      @(negedge clock);
      end_of_test <= 1'b0;
      if (fail_count == 0) begin
         $display("Regression PASS");
      end else begin
         $display("Regression FAIL");
      end
      $finish;
   end

endmodule

`default_nettype wire
